// ===== sv/vn2d_pkg.sv =====
// Shared types and constants for the 2D value noise pipeline.
`default_nettype none

package vn2d_pkg;

  // Register stages from an accepted point to the noise output register.
  localparam int unsigned NUM_STAGES = 7;

  // Corner order used on every corner bus.
  localparam int unsigned NCORNER = 4;
  localparam int unsigned C00 = 0;
  localparam int unsigned C10 = 1;
  localparam int unsigned C01 = 2;
  localparam int unsigned C11 = 3;

  typedef logic [15:0] sample_t;
  typedef sample_t [NCORNER-1:0] corner_vals_t;

  // Lattice hash.
  localparam logic [31:0] HASH_MUL_X = 32'd374761393;
  localparam logic [31:0] HASH_MUL_Y = 32'd668265263;
  localparam logic [30:0] HASH_MOD   = 31'd1274126177;

  // floor(2^47 / HASH_MOD), used to scale the residue to Q0.16 without a divider.
  localparam logic [16:0] HASH_RECIP = 17'((64'd1 << 47) / 64'd1274126177);

  // Quintic fade coefficients.
  localparam logic [21:0] FADE_C5 = 22'd6;
  localparam logic [21:0] FADE_C4 = 22'd15;
  localparam logic [21:0] FADE_C3 = 22'd10;

endpackage

`default_nettype wire

// ===== sv/vn2d_hash.sv =====
// Five-stage corner hash: lattice products, hash sums, residue, reciprocal scale, fix-up.
`default_nettype none

module vn2d_hash (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  vld_i,
  input  wire logic [31:0]           pos_x_i,
  input  wire logic [31:0]           pos_y_i,
  output      vn2d_pkg::corner_vals_t corner_o
);
  import vn2d_pkg::*;

  // Stage 1: products of floor and ceiling coordinates with the hash multipliers.
  logic [15:0] fx, fy;
  logic [16:0] cx, cy;
  logic [31:0] fx_w, fy_w, cx_w, cy_w;
  logic [31:0] mx0_d, mx1_d, my0_d, my1_d;
  logic [31:0] mx0_q, mx1_q, my0_q, my1_q;

  always_comb begin
    fx   = pos_x_i[31:16];
    fy   = pos_y_i[31:16];
    cx   = {fx[15], fx} + {16'd0, |pos_x_i[15:0]};
    cy   = {fy[15], fy} + {16'd0, |pos_y_i[15:0]};
    fx_w = {{16{fx[15]}}, fx};
    fy_w = {{16{fy[15]}}, fy};
    cx_w = {{15{cx[16]}}, cx};
    cy_w = {{15{cy[16]}}, cy};
    mx0_d = fx_w * HASH_MUL_X;
    mx1_d = cx_w * HASH_MUL_X;
    my0_d = fy_w * HASH_MUL_Y;
    my1_d = cy_w * HASH_MUL_Y;
  end

  always_ff @(posedge clk_i) begin
    mx0_q <= mx0_d;
    mx1_q <= mx1_d;
    my0_q <= my0_d;
    my1_q <= my1_d;
  end

  // Stage 2: one 32-bit hash per corner, wrapping.
  logic [NCORNER-1:0][31:0] h_d, h_q;

  always_comb begin
    h_d[C00] = mx0_q + my0_q;
    h_d[C10] = mx1_q + my0_q;
    h_d[C01] = mx0_q + my1_q;
    h_d[C11] = mx1_q + my1_q;
  end

  always_ff @(posedge clk_i) begin
    h_q <= h_d;
  end

  // Stage 3: non-negative residue. The signed hash lies within two moduli of
  // zero, so one of four candidates is always the answer.
  function automatic logic [30:0] residue(input logic [31:0] h);
    logic signed [33:0] hs, sub1, add1, add2;
    logic        [30:0] r;
    hs   = $signed({{2{h[31]}}, h});
    sub1 = hs - $signed({3'b000, HASH_MOD});
    add1 = hs + $signed({3'b000, HASH_MOD});
    add2 = hs + $signed({2'b00, HASH_MOD, 1'b0});
    if (!h[31]) begin
      r = sub1[33] ? h[30:0] : sub1[30:0];
    end else begin
      r = add1[33] ? add2[30:0] : add1[30:0];
    end
    return r;
  endfunction

  logic [NCORNER-1:0][30:0] r_d, r_q;

  always_comb begin
    for (int i = 0; i < NCORNER; i++) begin
      r_d[i] = residue(h_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
  end

  // Stage 4: quotient estimate by reciprocal; it is exact or one too small.
  logic [NCORNER-1:0][47:0] pr;
  logic [NCORNER-1:0][15:0] qe_d, qe_q;
  logic [NCORNER-1:0][30:0] r4_q;

  always_comb begin
    for (int i = 0; i < NCORNER; i++) begin
      pr[i]   = {17'd0, r_q[i]} * {31'd0, HASH_RECIP};
      qe_d[i] = pr[i][46:31];
    end
  end

  always_ff @(posedge clk_i) begin
    qe_q <= qe_d;
    r4_q <= r_q;
  end

  // Stage 5: bump the estimate when the remainder still holds a full modulus.
  logic [NCORNER-1:0][46:0] qm, rem;
  corner_vals_t             cv_d, cv_q;

  always_comb begin
    for (int i = 0; i < NCORNER; i++) begin
      qm[i]   = {31'd0, qe_q[i]} * {16'd0, HASH_MOD};
      rem[i]  = {r4_q[i], 16'd0} - qm[i];
      cv_d[i] = (rem[i] >= {16'd0, HASH_MOD}) ? qe_q[i] + 16'd1 : qe_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    cv_q <= cv_d;
  end

  assign corner_o = cv_q;

  // A residue that has reached the modulus would overflow the Q0.16 scaling.
  a_residue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_i |-> (r_q[C00] < HASH_MOD) && (r_q[C10] < HASH_MOD) &&
              (r_q[C01] < HASH_MOD) && (r_q[C11] < HASH_MOD))
    else $error("corner residue not reduced below the modulus");

endmodule

`default_nettype wire

// ===== sv/vn2d_fade.sv =====
// Five-stage quintic fade 6t^5 - 15t^4 + 10t^3 with truncating powers.
`default_nettype none

module vn2d_fade (
  input  wire logic        clk_i,
  input  wire logic [15:0] t_i,
  output      logic [15:0] w_o
);
  import vn2d_pkg::*;

  logic [31:0] p1, p2, p3, p4;
  logic [15:0] s1_t_q, s1_t2_q;
  logic [15:0] s2_t_q, s2_t3_q;
  logic [15:0] s3_t_q, s3_t3_q, s3_t4_q;
  logic [15:0] s4_t3_q, s4_t4_q, s4_t5_q;
  logic [21:0] f_w;
  logic [15:0] w_d, w_q;

  always_comb begin
    p1 = t_i * t_i;
    p2 = s1_t2_q * s1_t_q;
    p3 = s2_t3_q * s2_t_q;
    p4 = s3_t4_q * s3_t_q;
  end

  always_ff @(posedge clk_i) begin
    s1_t_q  <= t_i;
    s1_t2_q <= p1[31:16];
    s2_t_q  <= s1_t_q;
    s2_t3_q <= p2[31:16];
    s3_t_q  <= s2_t_q;
    s3_t3_q <= s2_t3_q;
    s3_t4_q <= p3[31:16];
    s4_t3_q <= s3_t3_q;
    s4_t4_q <= s3_t4_q;
    s4_t5_q <= p4[31:16];
  end

  // The polynomial can dip below zero or pass one from truncation; clamp it.
  always_comb begin
    f_w = FADE_C5 * {6'd0, s4_t5_q} - FADE_C4 * {6'd0, s4_t4_q}
        + FADE_C3 * {6'd0, s4_t3_q};
    if (f_w[21]) begin
      w_d = 16'd0;
    end else if (|f_w[20:16]) begin
      w_d = 16'hFFFF;
    end else begin
      w_d = f_w[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d;
  end

  assign w_o = w_q;

endmodule

`default_nettype wire

// ===== sv/vn2d_blend.sv =====
// Two-stage bilinear blend: along x for both rows, then along y.
`default_nettype none

module vn2d_blend (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   vld_i,
  input  wire vn2d_pkg::corner_vals_t corner_i,
  input  wire logic [15:0]            wx_i,
  input  wire logic [15:0]            wy_i,
  output      logic [15:0]            noise_o
);
  import vn2d_pkg::*;

  // a + (w * (b - a)) / 65536 with the quotient truncated toward zero.
  function automatic logic [15:0] lerp(input logic [15:0] a, input logic [15:0] b,
                                       input logic [15:0] w);
    logic signed [16:0] d;
    logic signed [33:0] p;
    logic signed [33:0] pa;
    logic        [17:0] sum;
    d   = $signed({1'b0, b}) - $signed({1'b0, a});
    p   = $signed({1'b0, w}) * d;
    pa  = p[33] ? p + 34'sd65535 : p;
    sum = {2'b00, a} + pa[33:16];
    return sum[15:0];
  endfunction

  logic [15:0] a_q, b_q, wy_q, noise_q;

  always_ff @(posedge clk_i) begin
    a_q  <= lerp(corner_i[C00], corner_i[C10], wx_i);
    b_q  <= lerp(corner_i[C01], corner_i[C11], wx_i);
    wy_q <= wy_i;
  end

  always_ff @(posedge clk_i) begin
    noise_q <= lerp(a_q, b_q, wy_q);
  end

  assign noise_o = noise_q;

  // The blended value never leaves the interval spanned by the two row values.
  a_between_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_i |-> ((noise_q >= $past(a_q)) && (noise_q <= $past(b_q))) ||
              ((noise_q >= $past(b_q)) && (noise_q <= $past(a_q))))
    else $error("blend result outside the row values");

endmodule

`default_nettype wire

// ===== sv/value_noise_2d_top.sv =====
// Top level of the 2D value noise pipeline with quintic fade.
//
// Input: a point (pos_x_i, pos_y_i), both signed Q16.16, is transferred at a
// rising edge where start is high and busy is low. busy is held low, so a new
// point may be transferred at every edge.
// Output: noise_o (unsigned Q0.16) is valid for exactly one cycle while done_o
// is high; the transfer completes at the edge that ends that cycle.
// Path: a transferred point passes through seven register stages before its
// result is in noise_o and done_o is high.
// Throughput: one point per cycle, set by the fully pipelined path; each hash
// stage holds at most one multiply and one wide add or subtract and compare,
// the fade powers run in parallel with the hash, and the blend follows both.
// Reset: rst_ni clears only the valid pipeline, so no done_o pulse appears for
// points in flight when reset is asserted. Data registers are not reset.
// The receiver has no way to hold results back, so the pipeline never stalls
// and results leave in the order their points arrived.
`default_nettype none

module value_noise_2d_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output      logic        busy,
  input  wire logic [31:0] pos_x_i,
  input  wire logic [31:0] pos_y_i,
  output      logic        done_o,
  output      logic [15:0] noise_o
);
  import vn2d_pkg::*;

  logic [NUM_STAGES-1:0] vld_d, vld_q;
  logic                  take;
  corner_vals_t          corners;
  logic [15:0]           wx, wy;

  assign busy = 1'b0;
  assign take = start & ~busy;

  assign vld_d = {vld_q[NUM_STAGES-2:0], take};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  vn2d_hash u_hash (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vld_i    (vld_q[2]),
    .pos_x_i  (pos_x_i),
    .pos_y_i  (pos_y_i),
    .corner_o (corners)
  );

  vn2d_fade u_fade_x (
    .clk_i (clk_i),
    .t_i   (pos_x_i[15:0]),
    .w_o   (wx)
  );

  vn2d_fade u_fade_y (
    .clk_i (clk_i),
    .t_i   (pos_y_i[15:0]),
    .w_o   (wy)
  );

  vn2d_blend u_blend (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vld_i    (vld_q[NUM_STAGES-1]),
    .corner_i (corners),
    .wx_i     (wx),
    .wy_i     (wy),
    .noise_o  (noise_o)
  );

  assign done_o = vld_q[NUM_STAGES-1];

  // Every transfer in gives one result, and no result appears without a transfer.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> ##7 done_o)
    else $error("accepted point produced no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(take, 7))
    else $error("result strobe without an accepted point");

endmodule

`default_nettype wire

// ===== bench/tb_value_noise_2d_top.sv =====
// Self-checking testbench for value_noise_2d_top: directed and random points against a predictor.
`default_nettype none

module tb_value_noise_2d_top;
  timeunit 1ns;
  timeprecision 1ps;

  import vn2d_pkg::*;

  localparam logic [31:0] MUL_X = 32'd374761393;
  localparam logic [31:0] MUL_Y = 32'd668265263;
  localparam longint HASH_MODULUS = 64'sd1274126177;
  localparam int NUM_RANDOM = 550;
  localparam int DRAIN_LIMIT = 2000;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic        known;
    logic [15:0] noise;
  } point_row_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [15:0] noise;
  } noise_exp_t;

  // A typed-in noise value is used only where it is obvious: the origin hashes to zero.
  localparam int NUM_ROWS = 17;
  localparam point_row_t DIRECTED_POINTS [NUM_ROWS] = '{
    '{32'h0000_0000, 32'h0000_0000, 1'b1, 16'h0000},
    '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 16'h0000},
    '{32'h8000_0000, 32'h8000_0000, 1'b0, 16'h0000},
    '{32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 16'h0000},
    '{32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 16'h0000},
    '{32'h0001_0000, 32'h0002_0000, 1'b0, 16'h0000},
    '{32'hFFFF_0000, 32'hFFFD_0000, 1'b0, 16'h0000},
    '{32'h0000_8000, 32'h0000_0000, 1'b0, 16'h0000},
    '{32'h0000_0000, 32'h0000_8000, 1'b0, 16'h0000},
    '{32'h0000_0001, 32'h0000_FFFF, 1'b0, 16'h0000},
    '{32'h0000_FFFF, 32'h0000_0001, 1'b0, 16'h0000},
    '{32'h7FFF_8000, 32'h7FFF_0000, 1'b0, 16'h0000},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 16'h0000},
    '{32'h8000_0001, 32'h8000_FFFF, 1'b0, 16'h0000},
    '{32'h1234_5678, 32'h9ABC_DEF0, 1'b0, 16'h0000},
    '{32'hFFFF_8000, 32'h0000_4000, 1'b0, 16'h0000},
    '{32'h8000_0000, 32'h0000_0000, 1'b0, 16'h0000}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic        done_o;
  logic [15:0] noise_o;

  logic        row_known;
  logic [15:0] row_noise;
  logic        took_point;
  int          mismatches;
  noise_exp_t  noise_expected [$];

  value_noise_2d_top uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .pos_x_i (pos_x),
    .pos_y_i (pos_y),
    .done_o  (done_o),
    .noise_o (noise_o)
  );

  always #4 clk_i = ~clk_i;

  // Pseudo-random fraction of one lattice corner, as Q0.16.
  function automatic logic [15:0] lattice_value(logic [31:0] cx, logic [31:0] cy);
    logic [31:0] h;
    longint      s;
    longint      r;
    h = cx * MUL_X + cy * MUL_Y;
    s = longint'(signed'(h));
    r = s % HASH_MODULUS;
    if (r < 0) begin
      r = r + HASH_MODULUS;
    end
    return 16'((r << 16) / HASH_MODULUS);
  endfunction

  function automatic longint fade_weight(logic [15:0] t);
    longint tt;
    longint t2;
    longint t3;
    longint t4;
    longint t5;
    longint f;
    tt = longint'(t);
    t2 = (tt * tt) >> 16;
    t3 = (t2 * tt) >> 16;
    t4 = (t3 * tt) >> 16;
    t5 = (t4 * tt) >> 16;
    f = 6 * t5 - 15 * t4 + 10 * t3;
    if (f < 0) begin
      f = 0;
    end
    if (f > 65535) begin
      f = 65535;
    end
    return f;
  endfunction

  // Division of a signed longint truncates toward zero, which keeps the blend between a and b.
  function automatic longint mix(longint a, longint b, longint w);
    return a + (w * (b - a)) / 65536;
  endfunction

  function automatic logic [15:0] noise_at(logic [31:0] px, logic [31:0] py);
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    longint             x0;
    longint             y0;
    longint             x1;
    longint             y1;
    longint             wx;
    longint             wy;
    longint             a;
    longint             b;
    fx = signed'(px) >>> 16;
    fy = signed'(py) >>> 16;
    x0 = longint'(fx);
    y0 = longint'(fy);
    x1 = (px[15:0] != 16'd0) ? x0 + 1 : x0;
    y1 = (py[15:0] != 16'd0) ? y0 + 1 : y0;
    wx = fade_weight(px[15:0]);
    wy = fade_weight(py[15:0]);
    a = mix(lattice_value(32'(x0), 32'(y0)), lattice_value(32'(x1), 32'(y0)), wx);
    b = mix(lattice_value(32'(x0), 32'(y1)), lattice_value(32'(x1), 32'(y1)), wx);
    return 16'(mix(a, b, wy));
  endfunction

  // One random coordinate, biased toward small cells, edge fractions and the range ends.
  function automatic logic [31:0] random_coord();
    int          cell_idx;
    logic [15:0] frac;
    frac = 16'($urandom_range(65535));
    case ($urandom_range(4))
      0: return $urandom;
      1: cell_idx = int'($urandom_range(8)) - 4;
      2: begin
        cell_idx = int'($urandom_range(65535)) - 32768;
        case ($urandom_range(3))
          0: frac = 16'h0000;
          1: frac = 16'h0001;
          2: frac = 16'h8000;
          default: frac = 16'hFFFF;
        endcase
      end
      3: begin
        case ($urandom_range(3))
          0: cell_idx = 32767;
          1: cell_idx = -32768;
          2: cell_idx = -1;
          default: cell_idx = 0;
        endcase
      end
      default: begin
        cell_idx = int'($urandom_range(65535)) - 32768;
        frac = 16'h0000;
      end
    endcase
    return {cell_idx[15:0], frac};
  endfunction

  // Drives one point from a falling edge and returns at the falling edge after its transfer.
  task automatic send_point(logic [31:0] x, logic [31:0] y, logic known, logic [15:0] noise);
    start = 1'b1;
    pos_x = x;
    pos_y = y;
    row_known = known;
    row_noise = noise;
    do begin
      @(negedge clk_i);
    end while (!took_point);
  endtask

  // Each idle cycle is drawn on its own, so about one cycle in five is idle.
  task automatic maybe_idle(bit allowed);
    if (allowed) begin
      while ($urandom_range(99) < 19) begin
        start = 1'b0;
        pos_x = $urandom;
        pos_y = $urandom;
        @(negedge clk_i);
      end
    end
  endtask

  always @(posedge clk_i) begin
    noise_exp_t got;
    if (!rst_ni) begin
      took_point <= 1'b0;
    end else begin
      took_point <= start && !busy;
      if (start && !busy) begin
        got.x = pos_x;
        got.y = pos_y;
        got.noise = row_known ? row_noise : noise_at(pos_x, pos_y);
        noise_expected.push_back(got);
      end
      if (done_o) begin
        if (noise_expected.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %h", $time, noise_o);
          mismatches++;
        end else begin
          got = noise_expected.pop_front();
          if (noise_o !== got.noise) begin
            $display("%0t: noise mismatch at (%h, %h): expected %h, actual %h",
                     $time, got.x, got.y, got.noise, noise_o);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin
    int waited;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    start = 1'b0;
    pos_x = '0;
    pos_y = '0;
    row_known = 1'b0;
    row_noise = '0;
    mismatches = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (DIRECTED_POINTS[i]) begin
      send_point(DIRECTED_POINTS[i].x, DIRECTED_POINTS[i].y,
                 DIRECTED_POINTS[i].known, DIRECTED_POINTS[i].noise);
      maybe_idle(1'b1);
    end

    // A back-to-back stretch in the middle keeps the pipeline full.
    for (int i = 0; i < NUM_RANDOM; i++) begin
      send_point(random_coord(), random_coord(), 1'b0, 16'h0000);
      maybe_idle(!(i >= 200 && i < 350));
    end
    start = 1'b0;

    waited = 0;
    while (noise_expected.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (NUM_STAGES + 4) @(posedge clk_i);
    if (noise_expected.size() != 0) begin
      $display("%0t: %0d results never arrived: expected %h, actual none",
               $time, noise_expected.size(), noise_expected[0].noise);
      mismatches++;
    end

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire
